// ----- rtl/core/ucpd_pkg.sv -----
// shared types and constants for the utf-8 code point decoder
package ucpd_pkg;

    localparam int CP_W        = 21;
    localparam int BYTE_W      = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] ASCII_TOP   = 8'h7f;
    localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hc2;
    localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hf4;
    localparam logic [1:0]        CONT_TAG    = 2'b10;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00fffd;
    localparam logic [CP_W-1:0] MAX_CP         = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LO        = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI        = 21'h00dfff;
    localparam logic [CP_W-1:0] MIN_CP_2       = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3       = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4       = 21'h010000;

    // sequence length in continuation bytes
    localparam logic [1:0] SEQ_2BYTE = 2'd1;
    localparam logic [1:0] SEQ_3BYTE = 2'd2;
    localparam logic [1:0] SEQ_4BYTE = 2'd3;

    typedef enum logic [2:0] {
        BYTE_ASCII,
        BYTE_LEAD2,
        BYTE_LEAD3,
        BYTE_LEAD4,
        BYTE_BAD
    } byte_class_t;

    // one queued job: some replacement results, then optionally one final result
    typedef struct packed {
        logic [1:0]      n_fffd;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
    } job_t;

endpackage

// ----- rtl/core/ucpd_front.sv -----
// front end: takes bytes, tracks the pending sequence and builds result jobs
module ucpd_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ucpd_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           push,
    output ucpd_pkg::job_t                 push_job
);

    logic [ucpd_pkg::CP_W-1:0] pv_reg, pv_next;
    logic [1:0] need_reg, need_next;
    logic [1:0] taken_reg, taken_next;
    logic [1:0] len_reg, len_next;

    logic                        accept;
    logic                        pending;
    logic                        is_cont;
    ucpd_pkg::byte_class_t       bclass;
    logic [ucpd_pkg::CP_W-1:0]   pv_shift;
    logic [ucpd_pkg::CP_W-1:0]   min_cp;
    logic                        bad_value;
    ucpd_pkg::job_t              job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign pending  = (need_reg != 2'd0);
    assign is_cont  = (s_tdata[7:6] == ucpd_pkg::CONT_TAG);
    assign pv_shift = {pv_reg[ucpd_pkg::CP_W-7:0], s_tdata[5:0]};

    always_comb begin
        case (s_tdata) inside
            [8'h00:ucpd_pkg::ASCII_TOP]:           bclass = ucpd_pkg::BYTE_ASCII;
            [ucpd_pkg::LEAD2_LO:ucpd_pkg::LEAD2_HI]: bclass = ucpd_pkg::BYTE_LEAD2;
            [ucpd_pkg::LEAD3_LO:ucpd_pkg::LEAD3_HI]: bclass = ucpd_pkg::BYTE_LEAD3;
            [ucpd_pkg::LEAD4_LO:ucpd_pkg::LEAD4_HI]: bclass = ucpd_pkg::BYTE_LEAD4;
            default:                               bclass = ucpd_pkg::BYTE_BAD;
        endcase
    end

    always_comb begin
        case (len_reg)
            ucpd_pkg::SEQ_2BYTE: min_cp = ucpd_pkg::MIN_CP_2;
            ucpd_pkg::SEQ_3BYTE: min_cp = ucpd_pkg::MIN_CP_3;
            default:             min_cp = ucpd_pkg::MIN_CP_4;
        endcase
    end

    assign bad_value = (pv_shift < min_cp) || (pv_shift > ucpd_pkg::MAX_CP) ||
                       ((pv_shift >= ucpd_pkg::SURR_LO) && (pv_shift <= ucpd_pkg::SURR_HI));

    always_comb begin
        pv_next    = pv_reg;
        need_next  = need_reg;
        taken_next = taken_reg;
        len_next   = len_reg;
        job        = '0;
        if (s_tlast) begin
            if (pending) begin
                job.n_fffd = 2'd1 + taken_reg;
                pv_next    = '0;
                need_next  = 2'd0;
                taken_next = 2'd0;
                len_next   = 2'd0;
            end
        end else if (pending && is_cont) begin
            pv_next    = pv_shift;
            need_next  = need_reg - 2'd1;
            taken_next = taken_reg + 2'd1;
            if (need_reg == 2'd1) begin
                job.has_final = 1'b1;
                job.final_cp  = bad_value ? ucpd_pkg::REPLACEMENT_CP : pv_shift;
                pv_next       = '0;
                taken_next    = 2'd0;
                len_next      = 2'd0;
            end
        end else begin
            // new byte; a broken sequence first replays the lead and taken continuations
            if (pending) begin
                job.n_fffd = 2'd1 + taken_reg;
            end
            pv_next    = '0;
            need_next  = 2'd0;
            taken_next = 2'd0;
            len_next   = 2'd0;
            case (bclass)
                ucpd_pkg::BYTE_ASCII: begin
                    job.has_final = 1'b1;
                    job.final_cp  = {13'd0, s_tdata};
                end
                ucpd_pkg::BYTE_LEAD2: begin
                    pv_next   = {16'd0, s_tdata[4:0]};
                    need_next = ucpd_pkg::SEQ_2BYTE;
                    len_next  = ucpd_pkg::SEQ_2BYTE;
                end
                ucpd_pkg::BYTE_LEAD3: begin
                    pv_next   = {17'd0, s_tdata[3:0]};
                    need_next = ucpd_pkg::SEQ_3BYTE;
                    len_next  = ucpd_pkg::SEQ_3BYTE;
                end
                ucpd_pkg::BYTE_LEAD4: begin
                    pv_next   = {18'd0, s_tdata[2:0]};
                    need_next = ucpd_pkg::SEQ_4BYTE;
                    len_next  = ucpd_pkg::SEQ_4BYTE;
                end
                default: begin
                    job.has_final = 1'b1;
                    job.final_cp  = ucpd_pkg::REPLACEMENT_CP;
                end
            endcase
        end
    end

    assign push     = accept && ((job.n_fffd != 2'd0) || job.has_final);
    assign push_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= '0;
            need_reg  <= 2'd0;
            taken_reg <= 2'd0;
            len_reg   <= 2'd0;
        end else if (accept) begin
            pv_reg    <= pv_next;
            need_reg  <= need_next;
            taken_reg <= taken_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- rtl/core/ucpd_queue.sv -----
// short job queue between front and back
module ucpd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ucpd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ucpd_pkg::job_t head_job
);

    ucpd_pkg::job_t mem [ucpd_pkg::QUEUE_DEPTH];

    logic [ucpd_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ucpd_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                          do_pop;

    localparam logic [ucpd_pkg::QUEUE_AW:0] DEPTH_CNT =
        (ucpd_pkg::QUEUE_AW+1)'(ucpd_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head_job  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/ucpd_back.sv -----
// back end: expands each job into result items behind an output register
module ucpd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              not_empty,
    input  ucpd_pkg::job_t                    head_job,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ucpd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [ucpd_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                             m_tlast_reg;
    logic [1:0]                       sent_reg, sent_next;

    logic                      load;
    logic                      emit_fffd;
    logic                      emit_last;
    logic [ucpd_pkg::CP_W-1:0] emit_cp;

    assign load      = !m_tvalid_reg || m_tready;
    assign emit_fffd = (sent_reg < head_job.n_fffd);
    assign emit_cp   = emit_fffd ? ucpd_pkg::REPLACEMENT_CP : head_job.final_cp;
    assign emit_last = emit_fffd ? (!head_job.has_final && (sent_reg == head_job.n_fffd - 2'd1))
                                 : 1'b1;
    assign pop       = load && not_empty && emit_last;

    always_comb begin
        sent_next     = sent_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = not_empty;
            if (not_empty) begin
                sent_next = emit_last ? 2'd0 : sent_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            sent_reg     <= 2'd0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            sent_reg     <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && not_empty) begin
            m_tdata_reg <= {3'd0, emit_cp};
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/core/utf8_code_point_decoder_unit.sv -----
// top level of the utf-8 code point decoder
// Decodes a UTF-8 byte stream into Unicode code points. One byte enters per
// item on the s_ side; s_tlast marks end of text and flushes any unfinished
// sequence (its data byte is ignored). Each code point leaves as one item on
// the m_ side, with m_tlast set on the last result that an input byte caused.
// Malformed input gives U+FFFD: an unfinished sequence gives one per byte it
// had taken, and a complete but overlong, surrogate or out-of-range sequence
// gives one. The front end takes one byte per cycle while the job queue is
// not full; the back end sends one result per cycle while m_tready is high,
// so a byte that causes k results (k is at most 4) holds the output while
// they leave. A four-entry job queue between the two lets a burst of such
// bytes, or a stalled m_ side, go on without blocking s_ at once; s_tready
// drops only when that queue is full. Results leave through an output register.
module utf8_code_point_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ucpd_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ucpd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [20:0] code_point, rest zero
    output logic                              m_tlast
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_not_empty;
    ucpd_pkg::job_t push_job;
    ucpd_pkg::job_t head_job;

    ucpd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    ucpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    ucpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (q_not_empty),
        .head_job  (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the utf-8 code point decoder
`timescale 1ns / 100ps

module tb_top;
    import ucpd_pkg::*;

    localparam int             RX_HOLD_CYCLES = 60;
    localparam int             OPENING_LEN    = 28;
    localparam int             RANDOM_ITEMS   = 152;
    localparam int             HOLD_AT        = OPENING_LEN + 60;
    localparam int             DRAIN_AT       = OPENING_LEN + 130;
    localparam logic [BYTE_W-1:0] CONT_MIN    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MAX    = 8'hbf;
    localparam logic [8:0]     EOT_FLAG       = 9'h100;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              eot;
        int                gap;
        logic              hold_rx;
        logic              drain_first;
    } text_item_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } decoded_point_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    utf8_code_point_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    text_item_t     text_bytes [$];
    decoded_point_t decoded_points [$];
    text_item_t     next_byte;
    decoded_point_t want;
    int             errors = 0;
    int             items_built = 0;
    int             tx_calm = 0;
    int             rx_calm = 0;
    int             idle_count = 0;
    int             rx_stall_left = 0;
    int             rx_hold_left = 0;
    int             rx_holds_asked = 0;
    int             rx_holds_done = 0;
    logic           byte_taken = 1'b0;

    // decoder state as the predictor sees it
    logic [CP_W-1:0] partial_cp = '0;
    logic [1:0]      conts_needed = '0;
    logic [1:0]      conts_seen = '0;
    logic [1:0]      seq_conts = '0;
    logic [CP_W-1:0] step_cps [0:3];
    int              step_n;

    function automatic int pick_idle(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic byte_class_t byte_kind(input logic [BYTE_W-1:0] b);
        if (b <= ASCII_TOP) return BYTE_ASCII;
        if (b >= LEAD2_LO && b <= LEAD2_HI) return BYTE_LEAD2;
        if (b >= LEAD3_LO && b <= LEAD3_HI) return BYTE_LEAD3;
        if (b >= LEAD4_LO && b <= LEAD4_HI) return BYTE_LEAD4;
        return BYTE_BAD;
    endfunction

    function automatic int conts_for(input byte_class_t kind);
        case (kind)
            BYTE_LEAD2: return int'(SEQ_2BYTE);
            BYTE_LEAD3: return int'(SEQ_3BYTE);
            BYTE_LEAD4: return int'(SEQ_4BYTE);
            default:    return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------- predictor

    task emit_cp(input logic [CP_W-1:0] cp);
        step_cps[step_n] = cp;
        step_n++;
    endtask

    task clear_sequence;
        partial_cp   = '0;
        conts_needed = '0;
        conts_seen   = '0;
        seq_conts    = '0;
    endtask

    // one replacement for the lead, one for each continuation already taken
    task flush_partial;
        emit_cp(REPLACEMENT_CP);
        for (int i = 0; i < conts_seen; i++) emit_cp(REPLACEMENT_CP);
        clear_sequence();
    endtask

    task open_lead(input logic [BYTE_W-1:0] b);
        case (byte_kind(b))
            BYTE_ASCII: emit_cp(CP_W'(b));
            BYTE_LEAD2: begin
                partial_cp = CP_W'(b[4:0]);
                seq_conts  = SEQ_2BYTE;
            end
            BYTE_LEAD3: begin
                partial_cp = CP_W'(b[3:0]);
                seq_conts  = SEQ_3BYTE;
            end
            BYTE_LEAD4: begin
                partial_cp = CP_W'(b[2:0]);
                seq_conts  = SEQ_4BYTE;
            end
            default: emit_cp(REPLACEMENT_CP);
        endcase
        if (byte_kind(b) inside {BYTE_LEAD2, BYTE_LEAD3, BYTE_LEAD4}) begin
            conts_needed = seq_conts;
            conts_seen   = '0;
        end
    endtask

    task decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
        logic [CP_W-1:0] floor_cp;
        decoded_point_t  pt;
        step_n = 0;
        if (eot) begin
            if (conts_needed != 0) flush_partial();
        end else if (conts_needed != 0) begin
            if (b[7:6] == CONT_TAG) begin
                partial_cp   = {partial_cp[CP_W-7:0], b[5:0]};
                conts_seen   = conts_seen + 2'd1;
                conts_needed = conts_needed - 2'd1;
                if (conts_needed == 0) begin
                    floor_cp = (seq_conts == SEQ_2BYTE) ? MIN_CP_2 :
                               (seq_conts == SEQ_3BYTE) ? MIN_CP_3 : MIN_CP_4;
                    if (partial_cp < floor_cp || partial_cp > MAX_CP ||
                        (partial_cp >= SURR_LO && partial_cp <= SURR_HI))
                        emit_cp(REPLACEMENT_CP);
                    else
                        emit_cp(partial_cp);
                    clear_sequence();
                end
            end else begin
                flush_partial();
                open_lead(b);
            end
        end else begin
            open_lead(b);
        end
        for (int i = 0; i < step_n; i++) begin
            pt.cp   = step_cps[i];
            pt.last = (i == step_n - 1);
            decoded_points.push_back(pt);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task add_byte(input logic [BYTE_W-1:0] data, input logic eot);
        text_item_t it;
        it.data        = data;
        it.eot         = eot;
        it.gap         = pick_idle(tx_calm);
        it.hold_rx     = (items_built == HOLD_AT);
        it.drain_first = (items_built == DRAIN_AT);
        // keep offering items back to back while the receiver holds off
        if (items_built > HOLD_AT && items_built <= HOLD_AT + 20) it.gap = 0;
        text_bytes.push_back(it);
        items_built++;
    endtask

    task encode_point(input logic [CP_W-1:0] cp);
        if (cp < MIN_CP_2) begin
            add_byte(cp[7:0], 1'b0);
        end else if (cp < MIN_CP_3) begin
            add_byte({3'b110, cp[10:6]}, 1'b0);
            add_byte({CONT_TAG, cp[5:0]}, 1'b0);
        end else if (cp < MIN_CP_4) begin
            add_byte({4'b1110, cp[15:12]}, 1'b0);
            add_byte({CONT_TAG, cp[11:6]}, 1'b0);
            add_byte({CONT_TAG, cp[5:0]}, 1'b0);
        end else begin
            add_byte({5'b11110, cp[20:18]}, 1'b0);
            add_byte({CONT_TAG, cp[17:12]}, 1'b0);
            add_byte({CONT_TAG, cp[11:6]}, 1'b0);
            add_byte({CONT_TAG, cp[5:0]}, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || byte_taken)) begin
            if (text_bytes.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (text_bytes[0].drain_first && decoded_points.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_count < text_bytes[0].gap) begin
                idle_count++;
                s_tvalid <= 1'b0;
            end else begin
                next_byte  = text_bytes.pop_front();
                idle_count = 0;
                s_tvalid  <= 1'b1;
                s_tdata   <= next_byte.data;
                s_tlast   <= next_byte.eot;
                if (next_byte.hold_rx) rx_holds_asked <= rx_holds_asked + 1;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_holds_done != rx_holds_asked) begin
            rx_holds_done++;
            rx_hold_left = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready     <= 1'b1;
            rx_stall_left = pick_idle(rx_calm);
        end
    end

    // ---------------------------------------------------------------- monitor

    // predict first so a result can never race its own input item
    always @(posedge aclk) begin
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_points.size() == 0) begin
                $display("%0t: unexpected result cp %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = decoded_points.pop_front();
                if (m_tdata !== OUT_TDATA_W'(want.cp) || m_tlast !== want.last) begin
                    $display("%0t: mismatch expected cp %h last %b, got cp %h last %b",
                             $time, want.cp, want.last, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [8:0]        opening [0:OPENING_LEN-1];
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] tail;
        logic [CP_W-1:0]   cp;
        byte_class_t       kind;
        int                r;
        int                n;

        opening = '{
            9'h000, 9'h07f,                         // ascii extremes
            9'h0df, 9'h0bf,                         // largest two-byte
            9'h0ed, 9'h0a0, 9'h080,                 // surrogate
            9'h0e0, 9'h080, 9'h080,                 // overlong three-byte
            9'h0f4, 9'h08f, 9'h0bf, 9'h0bf,         // largest scalar
            9'h0f4, 9'h090, 9'h080, 9'h080,         // above the scalar range
            9'h080, 9'h0ff,                         // invalid leads
            9'h0f0, 9'h090, 9'h080, 9'h041,         // missing continuation, four results
            9'h0e2, 9'h082, EOT_FLAG | 9'h0a5,      // end marker flushes a pending sequence
            EOT_FLAG | 9'h05a                       // end marker while idle
        };
        foreach (opening[i]) add_byte(opening[i][7:0], opening[i][8]);

        while (items_built < OPENING_LEN + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // well-formed scalar of random length
                case ($urandom_range(0, 3))
                    0: cp = CP_W'($urandom_range(0, 32'h7f));
                    1: cp = CP_W'($urandom_range(32'h80, 32'h7ff));
                    2: begin
                        cp = CP_W'($urandom_range(32'h800, 32'hffff));
                        if (cp >= SURR_LO && cp <= SURR_HI) cp[13] = ~cp[13];
                    end
                    default: cp = CP_W'($urandom_range(32'h10000, 32'h10ffff));
                endcase
                encode_point(cp);
            end else if (r < 65) begin
                // complete sequence with random content, which may be overlong, surrogate or out of range
                lead = BYTE_W'($urandom_range(LEAD2_LO, LEAD4_HI));
                add_byte(lead, 1'b0);
                n = conts_for(byte_kind(lead));
                for (int i = 0; i < n; i++)
                    add_byte(BYTE_W'($urandom_range(CONT_MIN, CONT_MAX)), 1'b0);
            end else if (r < 80) begin
                // broken sequence ended by a non-continuation or the end marker
                case ($urandom_range(0, 2))
                    0: lead = BYTE_W'($urandom_range(LEAD2_LO, LEAD2_HI));
                    1: lead = BYTE_W'($urandom_range(LEAD3_LO, LEAD3_HI));
                    default: lead = BYTE_W'($urandom_range(LEAD4_LO, LEAD4_HI));
                endcase
                kind = byte_kind(lead);
                add_byte(lead, 1'b0);
                n = $urandom_range(0, conts_for(kind) - 1);
                for (int i = 0; i < n; i++)
                    add_byte(BYTE_W'($urandom_range(CONT_MIN, CONT_MAX)), 1'b0);
                tail = BYTE_W'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(tail, 1'b1);
                end else begin
                    if (tail[7:6] == CONT_TAG) tail[6] = 1'b1;
                    add_byte(tail, 1'b0);
                end
            end else if (r < 93) begin
                add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end else begin
                add_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (text_bytes.size() == 0 && !s_tvalid);
        wait (decoded_points.size() == 0);
        repeat (10) @(posedge aclk);

        if (errors == 0 && decoded_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout, %0d results still expected", $time, decoded_points.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ucpd_pkg.sv
rtl/core/ucpd_front.sv
rtl/core/ucpd_queue.sv
rtl/core/ucpd_back.sv
rtl/core/utf8_code_point_decoder_unit.sv
tb/sv/tb_top.sv
